// ===== sv/ffha_pkg.sv =====
// Package of shared types and constants for the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned HeapWords = 4096;
  localparam int unsigned AW = 12;
  localparam int unsigned SW = 61;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [0:0] REG_HEAP_LIMIT = 1'b0;

  localparam int unsigned LS = 63;
  localparam int unsigned FR = 62;
  localparam int unsigned PF = 61;

  typedef enum logic [4:0] {
    S_IDLE,
    S_AW_RD,     // read header at cur
    S_AW_CHK,    // examine header
    S_GROW,      // append block at break
    S_GROW2,
    S_SPLIT,     // read chosen header for split
    S_SPLIT2,    // rewrite chosen header with need size
    S_MF_BP,     // mark_free: header of free block
    S_MF_RDH,
    S_MF_HDR,
    S_MF_RDN,
    S_MF_NXT,
    S_CH_RD,     // clear LS on chosen after split
    S_CH_WR,
    S_MU_RD,     // mark_used
    S_MU_HDR,
    S_MU_RDN,
    S_MU_NXT,
    S_F_RDH,
    S_F_H,
    S_F_RDN,
    S_F_N,
    S_F_RDB,
    S_F_B,
    S_F_RDP,
    S_F_P,
    S_F_WR,
    S_DONE
  } state_t;

endpackage

// ===== sv/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit boundary-tag heap allocator.
//
//  channel  direction  ports                                   handshake
//  in       input      in_command, in_request_bytes,           start & !busy
//                      in_block_address
//  out      output     out_result_address, out_status          done strobe
//  cfg      input      psel/penable/pwrite/paddr/pwdata/prdata  APB, pready=1
//
// Every command is a sequence of single-port memory steps; each read returns
// its data registered. An allocate walks the block headers and then updates
// headers, and a free merges neighbours and updates headers; the result beat
// follows the S_DONE state and busy stays high through it. The walk length
// sets the allocate time.
// Reset clears break and started flag; the heap memory is not cleared.
// The receiver cannot stall: done is high for one cycle per beat.
module first_fit_heap_allocator_top import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        in_command,
  input  logic [15:0] in_request_bytes,
  input  logic [11:0] in_block_address,
  output logic [11:0] out_result_address,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Heap memory, one port, registered read.
  logic [63:0] mem [HeapWords];
  logic [63:0] rdat;
  logic [AW-1:0] maddr;
  logic [63:0] wdat;
  logic          we;

  always_ff @(posedge clk) begin
    if (we) mem[maddr] <= wdat;
    rdat <= mem[maddr];
  end

  state_t state_r, state_nxt;
  logic [12:0] limit_r;
  logic [12:0] brk_r, brk_nxt;
  logic        started_r, started_nxt;
  logic [AW-1:0] cur_r, cur_nxt, ch_r, ch_nxt, p_r, p_nxt;
  logic [12:0]   steps_r, steps_nxt;
  logic [SW-1:0] need_r, need_nxt, tot_r, tot_nxt, orig_r, orig_nxt;
  logic          last_r, last_nxt, ret_r, ret_nxt;
  logic [63:0]   h_r, h_nxt;
  logic [11:0]   res_r, res_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          done_r, done_nxt;

  // Configuration register.
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_HEAP_LIMIT) ? {19'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 13'd4096;
    end else if (cfg_wr && paddr == REG_HEAP_LIMIT) begin
      limit_r <= pwdata[12:0];
    end
  end

  logic [12:0] lim;
  assign lim = (limit_r < 13'(HeapWords)) ? limit_r : 13'(HeapWords);

  logic [SW-1:0] rsz;
  assign rsz = rdat[SW-1:0];

  logic [AW-1:0] rnext;   // header index after block in rdat at cur_r
  assign rnext = cur_r + AW'(rsz) + AW'(1);

  logic [SW+1:0] grow_end;
  assign grow_end = (SW+2)'(brk_r) + (SW+2)'(need_r) + (SW+2)'(1);

  logic fitsr;
  assign fitsr = rdat[FR] && rsz >= need_r;

  // Next state and datapath.
  always_comb begin
    state_nxt = state_r;
    brk_nxt = brk_r; started_nxt = started_r;
    cur_nxt = cur_r; ch_nxt = ch_r; p_nxt = p_r; steps_nxt = steps_r;
    need_nxt = need_r; tot_nxt = tot_r; orig_nxt = orig_r;
    last_nxt = last_r; ret_nxt = ret_r; h_nxt = h_r;
    res_nxt = res_r; st_nxt = st_r; done_nxt = 1'b0;
    maddr = cur_r; wdat = 64'd0; we = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start && !busy) begin
          res_nxt = '0;
          st_nxt = ST_DONE;
          if (in_command == CMD_ALLOC) begin
            need_nxt = SW'((17'(in_request_bytes) + 17'd7) >> 3);
            cur_nxt = '0; steps_nxt = '0;
            if (in_request_bytes == 16'd0) begin
              st_nxt = ST_NULL; state_nxt = S_DONE;
            end else if (started_r) begin
              state_nxt = S_AW_RD;
            end else begin
              state_nxt = S_GROW;
            end
          end else begin
            cur_nxt = in_block_address - AW'(1);
            if (in_block_address == '0) begin
              st_nxt = ST_NULL; state_nxt = S_DONE;
            end else begin
              state_nxt = S_F_RDH;
            end
          end
        end
      end
      S_AW_RD: begin
        maddr = cur_r; state_nxt = S_AW_CHK;
      end
      S_AW_CHK: begin
        h_nxt = rdat;
        if (fitsr) begin
          ch_nxt = cur_r; orig_nxt = rsz; state_nxt = S_SPLIT;
        end else if (!rdat[LS] && steps_r < 13'(HeapWords)) begin
          cur_nxt = rnext; steps_nxt = steps_r + 13'd1; state_nxt = S_AW_RD;
        end else begin
          state_nxt = S_GROW;
        end
      end
      S_GROW: begin
        if (grow_end > (SW+2)'(lim)) begin
          st_nxt = ST_FULL; state_nxt = S_DONE;
        end else begin
          maddr = brk_r[AW-1:0]; we = 1'b1;
          wdat = {1'b1, 1'b0, started_r & h_r[FR], need_r};
          ch_nxt = brk_r[AW-1:0]; orig_nxt = need_r;
          brk_nxt = grow_end[12:0];
          state_nxt = started_r ? S_GROW2 : S_SPLIT;
          started_nxt = 1'b1;
        end
      end
      S_GROW2: begin
        // Old last block loses its last mark.
        maddr = cur_r; we = 1'b1;
        wdat = {1'b0, h_r[62:0]};
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        // Chosen header now in rdat only if walked; re-read here.
        maddr = ch_r; state_nxt = S_SPLIT2;
        if (!(orig_r > need_r + SW'(1))) state_nxt = S_MU_HDR;
      end
      S_SPLIT2: begin
        maddr = ch_r; we = 1'b1;
        wdat = {rdat[63:SW], need_r};
        cur_nxt = ch_r + AW'(need_r) + AW'(1);
        tot_nxt = orig_r - need_r - SW'(1);
        last_nxt = rdat[LS];
        ret_nxt = 1'b1;
        state_nxt = S_MF_BP;
        h_nxt = {rdat[LS], 2'b00, orig_r - need_r - SW'(1)};
      end
      S_MF_BP: begin
        // Write header of free block (h_r) then back pointer.
        maddr = cur_r; we = 1'b1; wdat = h_r | (64'd1 << FR);
        state_nxt = S_MF_RDH;
      end
      S_MF_RDH: begin
        maddr = cur_r + AW'(h_r[SW-1:0]); we = 1'b1;
        wdat = 64'(cur_r);
        state_nxt = h_r[LS] ? (ret_r ? S_CH_RD : S_DONE) : S_MF_RDN;
      end
      S_MF_RDN: begin
        maddr = cur_r + AW'(h_r[SW-1:0]) + AW'(1); state_nxt = S_MF_NXT;
      end
      S_MF_NXT: begin
        maddr = cur_r + AW'(h_r[SW-1:0]) + AW'(1); we = 1'b1;
        wdat = rdat | (64'd1 << PF);
        state_nxt = ret_r ? S_CH_RD : S_DONE;
      end
      S_CH_RD: begin
        maddr = ch_r; state_nxt = S_CH_WR;
      end
      S_CH_WR: begin
        maddr = ch_r; we = 1'b1; wdat = {1'b0, rdat[62:0]};
        state_nxt = S_MU_RD;
      end
      S_MU_RD: begin
        maddr = ch_r; state_nxt = S_MU_HDR;
      end
      S_MU_HDR: begin
        maddr = ch_r; we = 1'b1;
        wdat = rdat & ~(64'd1 << FR);
        h_nxt = rdat;
        state_nxt = rdat[LS] ? S_DONE : S_MU_RDN;
        res_nxt = ch_r + AW'(1);
      end
      S_MU_RDN: begin
        maddr = ch_r + AW'(h_r[SW-1:0]) + AW'(1); state_nxt = S_MU_NXT;
      end
      S_MU_NXT: begin
        maddr = ch_r + AW'(h_r[SW-1:0]) + AW'(1); we = 1'b1;
        wdat = rdat & ~(64'd1 << PF);
        state_nxt = S_DONE;
      end
      S_F_RDH: begin
        maddr = cur_r; state_nxt = S_F_H;
      end
      S_F_H: begin
        h_nxt = rdat; tot_nxt = rsz; last_nxt = rdat[LS];
        p_nxt = cur_r;
        state_nxt = rdat[LS] ? S_F_RDB : S_F_RDN;
      end
      S_F_RDN: begin
        maddr = cur_r + AW'(h_r[SW-1:0]) + AW'(1); state_nxt = S_F_N;
      end
      S_F_N: begin
        if (rdat[FR]) begin
          tot_nxt = tot_r + rsz + SW'(1); last_nxt = rdat[LS];
        end
        state_nxt = S_F_RDB;
      end
      S_F_RDB: begin
        maddr = cur_r - AW'(1);
        state_nxt = h_r[PF] ? S_F_B : S_F_WR;
      end
      S_F_B: begin
        p_nxt = rdat[AW-1:0]; state_nxt = S_F_RDP;
      end
      S_F_RDP: begin
        maddr = p_r; state_nxt = S_F_P;
      end
      S_F_P: begin
        tot_nxt = tot_r + rsz + SW'(1); h_nxt = rdat;
        state_nxt = S_F_WR;
      end
      S_F_WR: begin
        // Header composed in h_r, then mark_free sequence at p_r.
        cur_nxt = p_r; ret_nxt = 1'b0;
        h_nxt = {last_r, h_r[62:61], tot_r};
        state_nxt = S_MF_BP;
      end
      S_DONE: begin
        done_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; brk_r <= '0; started_r <= 1'b0; done_r <= 1'b0;
    end else begin
      state_r <= state_nxt; brk_r <= brk_nxt; started_r <= started_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; ch_r <= ch_nxt; p_r <= p_nxt; steps_r <= steps_nxt;
    need_r <= need_nxt; tot_r <= tot_nxt; orig_r <= orig_nxt;
    last_r <= last_nxt; ret_r <= ret_nxt;
    h_r <= h_nxt; res_r <= res_nxt; st_r <= st_nxt;
  end

  assign busy = (state_r != S_IDLE) || done_r;
  assign done = done_r;
  assign out_result_address = (st_r == ST_DONE) ? res_r : '0;
  assign out_status = st_r;

  // Checks.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done longer than one cycle");
  a_brk_lim: assert property (@(posedge clk) disable iff (!rst_n)
    brk_r <= 13'(HeapWords)) else $error("break past heap");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_full_null: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (out_status != ST_FULL || out_result_address == '0))
    else $error("bad full result");

endmodule
